// File: rtl/ckvt_pkg.sv
package ckvt_pkg;

    localparam int ACT_W = 2;

    typedef logic [ACT_W-1:0] t_act;

    localparam t_act ACT_ADD    = 2'd0;
    localparam t_act ACT_REMOVE = 2'd1;
    localparam t_act ACT_LOOKUP = 2'd2;
    localparam t_act ACT_UNUSED = 2'd3;

    // Control part of the request token that walks down the row of cells.
    typedef struct packed {
        logic valid;
        logic hit;
    } t_tok;

endpackage

// File: rtl/compacting_key_value_table.sv
// Compacting key/value table.
// Input channel: i_valid / o_stall with i_action, i_key, i_value_in. A request
// is taken at a rising edge with i_valid high and o_stall low. Actions: add or
// update, remove, lookup; code 3 changes nothing.
// Output channel: o_valid / i_stall with o_found, o_value_out, o_table_full and
// o_entry_count; one result per request, in request order.
// Entries live in a row of TABLE_DEPTH cells. An accepted request becomes a
// token that moves one cell per cycle; every cell compares its key as the
// token passes, and on a remove each later cell hands its entry to its left
// neighbor. The token always walks the full row, so o_valid rises only after
// the token has left the last cell, and no new request is taken while a
// token is in the row.
// A finished result waits in an output register (with one spare slot), so a
// new request is accepted while the receiver stalls; o_stall rises only while
// a token is in the row or both result slots are full.
// Reset (synchronous, active low) empties the table and drops any request in
// flight. Entry contents are not cleared; only slots below the count are used.
module compacting_key_value_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  ckvt_pkg::t_act                      i_action,
    input  logic [KEY_WIDTH-1:0]                i_key,
    input  logic [VALUE_WIDTH-1:0]              i_value_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_found,
    output logic [VALUE_WIDTH-1:0]              o_value_out,
    output logic                                o_table_full,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    o_entry_count
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Token chain: tok[g] enters cell g, tok[TABLE_DEPTH] leaves the last cell.
    ckvt_pkg::t_tok         tok       [0:TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] tok_value [0:TABLE_DEPTH];
    logic                   take      [0:TABLE_DEPTH-1];
    logic [KEY_WIDTH-1:0]   cell_key  [0:TABLE_DEPTH-1];
    logic [VALUE_WIDTH-1:0] cell_val  [0:TABLE_DEPTH-1];

    logic                   r_busy;
    logic [CNT_W-1:0]       r_count;
    ckvt_pkg::t_act         r_act;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_val;

    logic                   r_out_valid;
    logic                   r_out_found;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   r_out_full;
    logic [CNT_W-1:0]       r_out_count;

    logic                   r_pend_valid;
    logic                   r_pend_found;
    logic [VALUE_WIDTH-1:0] r_pend_value;
    logic                   r_pend_full;
    logic [CNT_W-1:0]       r_pend_count;

    logic                   accept;
    logic                   done;
    logic                   out_free;
    logic                   res_full;
    logic [CNT_W-1:0]       n_count;

    assign o_stall  = r_busy | r_pend_valid;
    assign accept   = i_valid && !o_stall;
    assign done     = tok[TABLE_DEPTH].valid;
    assign out_free = !r_out_valid || !i_stall;

    assign tok[0]       = '{valid: accept, hit: 1'b0};
    assign tok_value[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic                   nb_take;
        logic [KEY_WIDTH-1:0]   nb_key;
        logic [VALUE_WIDTH-1:0] nb_val;

        if (g == TABLE_DEPTH - 1) begin : g_last
            assign nb_take = 1'b0;
            assign nb_key  = '0;
            assign nb_val  = '0;
        end else begin : g_inner
            assign nb_take = take[g+1];
            assign nb_key  = cell_key[g+1];
            assign nb_val  = cell_val[g+1];
        end

        ckvt_cell #(
            .KEY_W (KEY_WIDTH),
            .VAL_W (VALUE_WIDTH),
            .CNT_W (CNT_W),
            .SLOT  (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_act       (r_act),
            .i_key       (r_key),
            .i_value     (r_val),
            .i_count     (r_count),
            .i_tok       (tok[g]),
            .i_tok_value (tok_value[g]),
            .o_tok       (tok[g+1]),
            .o_tok_value (tok_value[g+1]),
            .i_nb_take   (nb_take),
            .i_nb_key    (nb_key),
            .i_nb_val    (nb_val),
            .o_take      (take[g]),
            .o_key       (cell_key[g]),
            .o_val       (cell_val[g])
        );
    end

    always_comb begin
        res_full = (r_act == ckvt_pkg::ACT_ADD) && !tok[TABLE_DEPTH].hit &&
                   (r_count == DEPTH_CNT);
        n_count  = r_count;
        if ((r_act == ckvt_pkg::ACT_ADD) && !tok[TABLE_DEPTH].hit &&
            (r_count != DEPTH_CNT)) begin
            n_count = r_count + 1'b1;
        end else if ((r_act == ckvt_pkg::ACT_REMOVE) && tok[TABLE_DEPTH].hit) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_count <= n_count;
            end
            // A finished token finds the spare slot empty, since no request is
            // accepted while it is full.
            if (done) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_pend_valid <= 1'b1;
                end
            end else if (r_pend_valid && out_free) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action;
            r_key <= i_key;
            r_val <= i_value_in;
        end
        if (done && out_free) begin
            r_out_found <= tok[TABLE_DEPTH].hit;
            r_out_value <= tok_value[TABLE_DEPTH];
            r_out_full  <= res_full;
            r_out_count <= n_count;
        end else if (done) begin
            r_pend_found <= tok[TABLE_DEPTH].hit;
            r_pend_value <= tok_value[TABLE_DEPTH];
            r_pend_full  <= res_full;
            r_pend_count <= n_count;
        end else if (r_pend_valid && out_free) begin
            r_out_found <= r_pend_found;
            r_out_value <= r_pend_value;
            r_out_full  <= r_pend_full;
            r_out_count <= r_pend_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_value_out   = r_out_value;
    assign o_table_full  = r_out_full;
    assign o_entry_count = r_out_count;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("entry count above table depth");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> r_busy)
        else $error("token left the row with no request in flight");

    a_pend_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("spare result slot filled while output register empty");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !done |=> $stable(r_count))
        else $error("entry count changed with no request finishing");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (!o_found && (o_entry_count == DEPTH_CNT)))
        else $error("table full flag on a hit or below full depth");
`endif

endmodule

// File: rtl/ckvt_cell.sv
module ckvt_cell #(
    parameter int KEY_W = 32,
    parameter int VAL_W = 32,
    parameter int CNT_W = 9,
    parameter int SLOT  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request fields, held steady by the top level while a token is in flight.
    input  ckvt_pkg::t_act       i_act,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [VAL_W-1:0]     i_value,
    input  logic [CNT_W-1:0]     i_count,
    // Token from the previous cell.
    input  ckvt_pkg::t_tok       i_tok,
    input  logic [VAL_W-1:0]     i_tok_value,
    // Token to the next cell.
    output ckvt_pkg::t_tok       o_tok,
    output logic [VAL_W-1:0]     o_tok_value,
    // Entry of the next cell, taken when a remove compacts the table.
    input  logic                 i_nb_take,
    input  logic [KEY_W-1:0]     i_nb_key,
    input  logic [VAL_W-1:0]     i_nb_val,
    // This cell's entry, offered to the previous cell.
    output logic                 o_take,
    output logic [KEY_W-1:0]     o_key,
    output logic [VAL_W-1:0]     o_val
);

    localparam logic [CNT_W-1:0] SLOT_IDX = CNT_W'(SLOT);

    ckvt_pkg::t_tok   r_tok;
    logic [VAL_W-1:0] r_tok_value;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [KEY_W-1:0] n_key;
    logic [VAL_W-1:0] n_val;

    logic occupied;
    logic match;
    logic append;

    always_comb begin
        occupied = SLOT_IDX < i_count;
        match    = r_tok.valid && (i_act != ckvt_pkg::ACT_UNUSED) && occupied &&
                   (r_key == i_key);
        // The first free slot is reached only after every occupied slot has been
        // compared, so the hit flag is final here.
        append   = r_tok.valid && (i_act == ckvt_pkg::ACT_ADD) && !r_tok.hit &&
                   (SLOT_IDX == i_count);
        // Every occupied slot behind the removed one moves down by one.
        o_take   = r_tok.valid && (i_act == ckvt_pkg::ACT_REMOVE) && r_tok.hit && occupied;

        o_tok.valid = r_tok.valid;
        o_tok.hit   = r_tok.hit | match;
        o_tok_value = (match && (i_act == ckvt_pkg::ACT_LOOKUP)) ? r_val : r_tok_value;

        n_key = r_key;
        n_val = r_val;
        if (append) begin
            n_key = i_key;
            n_val = i_value;
        end else if (match && (i_act == ckvt_pkg::ACT_ADD)) begin
            n_val = i_value;
        end else if (i_nb_take) begin
            n_key = i_nb_key;
            n_val = i_nb_val;
        end
    end

    assign o_key = r_key;
    assign o_val = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.hit   <= i_tok.hit;
        r_tok_value <= i_tok_value;
        r_key       <= n_key;
        r_val       <= n_val;
    end

endmodule

// File: sim/compacting_key_value_table_tb.sv
module compacting_key_value_table_tb;

    localparam int DEPTH       = 256;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int HOLD_CYCLES = 1500;
    localparam int IDLE_LIMIT  = 20000;

    typedef struct packed {
        logic             found;
        logic [31:0]      value;
        logic             full;
        logic [CNT_W-1:0] count;
    } t_reply;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic             o_stall;
    ckvt_pkg::t_act   i_action   = ckvt_pkg::ACT_LOOKUP;
    logic [31:0]      i_key      = '0;
    logic [31:0]      i_value_in = '0;
    logic             o_valid;
    logic             i_stall    = 1'b0;
    logic             o_found;
    logic [31:0]      o_value_out;
    logic             o_table_full;
    logic [CNT_W-1:0] o_entry_count;

    // Mirror of the table contents, kept packed exactly like the block.
    logic [31:0] tbl_key [DEPTH];
    logic [31:0] tbl_val [DEPTH];
    int          tbl_count = 0;

    t_reply      due_replies [$];
    logic [31:0] key_pool [16];
    int          mismatches = 0;
    bit          quiet      = 1'b0;
    logic        hold_ask   = 1'b0;
    int          hold_left  = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    compacting_key_value_table #(
        .TABLE_DEPTH (DEPTH),
        .KEY_WIDTH   (32),
        .VALUE_WIDTH (32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_value_in    (i_value_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_value_out   (o_value_out),
        .o_table_full  (o_table_full),
        .o_entry_count (o_entry_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int find_entry(logic [31:0] key);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic t_reply apply_request(ckvt_pkg::t_act act, logic [31:0] key,
                                             logic [31:0] val);
        t_reply r;
        int     slot;
        r    = '0;
        slot = find_entry(key);
        case (act)
            ckvt_pkg::ACT_ADD: begin
                r.found = (slot >= 0);
                if (slot >= 0) begin
                    tbl_val[slot] = val;
                end else if (tbl_count == DEPTH) begin
                    r.full = 1'b1;
                end else begin
                    tbl_key[tbl_count] = key;
                    tbl_val[tbl_count] = val;
                    tbl_count++;
                end
            end
            ckvt_pkg::ACT_REMOVE: begin
                r.found = (slot >= 0);
                if (slot >= 0) begin
                    for (int j = slot; j < tbl_count - 1; j++) begin
                        tbl_key[j] = tbl_key[j + 1];
                        tbl_val[j] = tbl_val[j + 1];
                    end
                    tbl_count--;
                end
            end
            ckvt_pkg::ACT_LOOKUP: begin
                r.found = (slot >= 0);
                if (slot >= 0) r.value = tbl_val[slot];
            end
            default: ;
        endcase
        r.count = CNT_W'(tbl_count);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // Valid stays high from one request to the next unless an idle burst
    // comes in between, so it is never lowered and raised in one step.
    task automatic send_request(input ckvt_pkg::t_act act, input logic [31:0] key,
                                input logic [31:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_key      <= key;
        i_value_in <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        due_replies.push_back(apply_request(act, key, val));
    endtask

    task automatic send_random_request(input int add_pct, input int remove_pct);
        ckvt_pkg::t_act act;
        logic [31:0]    key;
        int             roll;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) act = ckvt_pkg::ACT_ADD;
        else if (roll < add_pct + remove_pct) act = ckvt_pkg::ACT_REMOVE;
        else if (roll < 95) act = ckvt_pkg::ACT_LOOKUP;
        else act = ckvt_pkg::ACT_UNUSED;
        roll = $urandom_range(0, 99);
        if (roll < 60 && tbl_count > 0) key = tbl_key[$urandom_range(0, tbl_count - 1)];
        else if (roll < 85) key = key_pool[$urandom_range(0, 15)];
        else key = $urandom;
        send_request(act, key, $urandom);
    endtask

    task automatic test_directed();
        send_request(ckvt_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(ckvt_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(ckvt_pkg::ACT_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(ckvt_pkg::ACT_ADD, 32'h0000_0000, 32'h0000_0000);
        send_request(ckvt_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ckvt_pkg::ACT_ADD, 32'h5A5A_A5A5, 32'h1234_5678);
        send_request(ckvt_pkg::ACT_ADD, 32'h8000_0001, 32'hDEAD_BEEF);
        send_request(ckvt_pkg::ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(ckvt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_request(ckvt_pkg::ACT_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(ckvt_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0);
        // Code 3 must leave a present key alone and report it as not found.
        send_request(ckvt_pkg::ACT_UNUSED, 32'h0000_0000, 32'h0);
        send_request(ckvt_pkg::ACT_LOOKUP, 32'h7FFF_FFFE, 32'h0);
        send_request(ckvt_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(ckvt_pkg::ACT_LOOKUP, 32'h8000_0001, 32'h0);
        send_request(ckvt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_request(ckvt_pkg::ACT_REMOVE, 32'h1111_1111, 32'h0);
        send_request(ckvt_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0);
        send_request(ckvt_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_request(ckvt_pkg::ACT_LOOKUP, 32'h5A5A_A5A5, 32'h0);
        send_request(ckvt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_request(ckvt_pkg::ACT_REMOVE, 32'h8000_0001, 32'h0);
    endtask

    task automatic test_fill_table();
        logic [31:0] key;
        while (tbl_count < DEPTH) begin
            do key = $urandom; while (find_entry(key) >= 0);
            send_request(ckvt_pkg::ACT_ADD, key, $urandom);
        end
        do key = $urandom; while (find_entry(key) >= 0);
        send_request(ckvt_pkg::ACT_ADD, key, $urandom);
        // An update of a present key still succeeds on a full table.
        send_request(ckvt_pkg::ACT_ADD, tbl_key[DEPTH - 1], $urandom);
        send_request(ckvt_pkg::ACT_LOOKUP, tbl_key[DEPTH - 1], $urandom);
        send_request(ckvt_pkg::ACT_LOOKUP, key, $urandom);
        send_request(ckvt_pkg::ACT_REMOVE, tbl_key[0], $urandom);
        send_request(ckvt_pkg::ACT_LOOKUP, tbl_key[DEPTH - 2], $urandom);
        send_request(ckvt_pkg::ACT_LOOKUP, tbl_key[0], $urandom);
        send_request(ckvt_pkg::ACT_ADD, key, $urandom);
        send_request(ckvt_pkg::ACT_LOOKUP, key, $urandom);
        do key = $urandom; while (find_entry(key) >= 0);
        send_request(ckvt_pkg::ACT_ADD, key, $urandom);
        send_request(ckvt_pkg::ACT_REMOVE, tbl_key[DEPTH / 2], $urandom);
        send_request(ckvt_pkg::ACT_REMOVE, tbl_key[tbl_count - 1], $urandom);
        send_request(ckvt_pkg::ACT_LOOKUP, tbl_key[tbl_count - 1], $urandom);
    endtask

    // The receiver goes quiet long enough for both result slots to fill,
    // after which the block has to stall further requests.
    task automatic test_backpressure();
        hold_ask <= 1'b1;
        @(posedge i_clk);
        hold_ask <= 1'b0;
        repeat (6) send_random_request(30, 30);
    endtask

    task automatic test_random();
        repeat (400) send_random_request(10, 60);
        repeat (400) send_random_request(50, 15);
    endtask

    task automatic test_no_idle();
        quiet = 1'b1;
        repeat (50) send_random_request(35, 30);
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_ask) begin
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            i_stall    <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst_left <= $urandom_range(0, 9);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_replies.size() == 0) begin
                report_mismatch("result with no request pending", o_value_out, 32'h0);
            end else begin
                want = due_replies.pop_front();
                if (o_found !== want.found)
                    report_mismatch("found", 32'(o_found), 32'(want.found));
                if (o_value_out !== want.value)
                    report_mismatch("value_out", o_value_out, want.value);
                if (o_table_full !== want.full)
                    report_mismatch("table_full", 32'(o_table_full), 32'(want.full));
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", 32'(o_entry_count), 32'(want.count));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_table();
        test_backpressure();
        test_random();
        test_no_idle();
        i_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        // Any stray result would have to show up within one walk of the row.
        repeat (DEPTH + 20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
